/* src/mcc_pkg.sv */
// ----------------------------------------------------------------------------
// mcc_pkg
// Shared types, character codes and code tables for the Morse codec.
// ----------------------------------------------------------------------------
package mcc_pkg;

  localparam int unsigned MaxSymbols = 6;
  localparam int unsigned NumCodes   = 45;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_E     = 8'h65;

  // dash = 1, first symbol most significant, right aligned
  typedef struct packed {
    logic       found;
    logic [2:0] len;
    logic [5:0] bits;
  } pattern_t;

  // work handed from front to back: optional bar, symbols, one char, newline
  typedef struct packed {
    logic       lead_bar;
    logic [2:0] nsym;
    logic [5:0] sym_bits;   // left aligned
    logic       sym_e;      // symbols print as 'e'
    logic       has_char;
    logic [7:0] chr;
    logic       trail_nl;
  } job_t;

  localparam logic [7:0] CODE_CHARS [NumCodes] = '{
    "a", "b", "c", "d", "e", "f", "g", "h", "i", "j", "k", "l", "m",
    "n", "o", "p", "q", "r", "s", "t", "u", "v", "w", "x", "y", "z",
    "1", "2", "3", "4", "5", "6", "7", "8", "9", "0",
    ",", ".", "?", ";", ":", "/", "+", "-", "="
  };

  function automatic pattern_t encode_pattern(logic [7:0] ch);
    pattern_t r;
    case (ch)
      "a": r = {1'b1, 3'd2, 6'b01};
      "b": r = {1'b1, 3'd4, 6'b1000};
      "c": r = {1'b1, 3'd4, 6'b1010};
      "d": r = {1'b1, 3'd3, 6'b100};
      "e": r = {1'b1, 3'd1, 6'b0};
      "f": r = {1'b1, 3'd4, 6'b0010};
      "g": r = {1'b1, 3'd3, 6'b110};
      "h": r = {1'b1, 3'd4, 6'b0000};
      "i": r = {1'b1, 3'd2, 6'b00};
      "j": r = {1'b1, 3'd4, 6'b0111};
      "k": r = {1'b1, 3'd3, 6'b101};
      "l": r = {1'b1, 3'd4, 6'b0100};
      "m": r = {1'b1, 3'd2, 6'b11};
      "n": r = {1'b1, 3'd2, 6'b10};
      "o": r = {1'b1, 3'd3, 6'b111};
      "p": r = {1'b1, 3'd4, 6'b0110};
      "q": r = {1'b1, 3'd4, 6'b1101};
      "r": r = {1'b1, 3'd3, 6'b010};
      "s": r = {1'b1, 3'd3, 6'b000};
      "t": r = {1'b1, 3'd1, 6'b1};
      "u": r = {1'b1, 3'd3, 6'b001};
      "v": r = {1'b1, 3'd4, 6'b0001};
      "w": r = {1'b1, 3'd3, 6'b011};
      "x": r = {1'b1, 3'd4, 6'b1001};
      "y": r = {1'b1, 3'd4, 6'b1011};
      "z": r = {1'b1, 3'd4, 6'b1100};
      "1": r = {1'b1, 3'd5, 6'b01111};
      "2": r = {1'b1, 3'd5, 6'b00111};
      "3": r = {1'b1, 3'd5, 6'b00011};
      "4": r = {1'b1, 3'd5, 6'b00001};
      "5": r = {1'b1, 3'd5, 6'b00000};
      "6": r = {1'b1, 3'd5, 6'b10000};
      "7": r = {1'b1, 3'd5, 6'b11000};
      "8": r = {1'b1, 3'd5, 6'b11100};
      "9": r = {1'b1, 3'd5, 6'b11110};
      "0": r = {1'b1, 3'd5, 6'b11111};
      ",": r = {1'b1, 3'd5, 6'b00100};
      ".": r = {1'b1, 3'd6, 6'b010101};
      "?": r = {1'b1, 3'd6, 6'b001100};
      ";": r = {1'b1, 3'd5, 6'b10101};
      ":": r = {1'b1, 3'd6, 6'b111000};
      "/": r = {1'b1, 3'd5, 6'b10010};
      "+": r = {1'b1, 3'd5, 6'b01010};
      "-": r = {1'b1, 3'd6, 6'b100001};
      "=": r = {1'b1, 3'd5, 6'b10001};
      default: r = '0;
    endcase
    return r;
  endfunction

  // patterns are unique, so matches can be merged with an or
  function automatic logic [7:0] decode_char(logic [2:0] len, logic [5:0] bits);
    pattern_t   p;
    logic [7:0] ch;
    logic       hit;
    ch  = '0;
    hit = 1'b0;
    for (int i = 0; i < NumCodes; i++) begin
      p = encode_pattern(CODE_CHARS[i]);
      if (p.len == len && p.bits == bits) begin
        ch  = ch | CODE_CHARS[i];
        hit = 1'b1;
      end
    end
    return hit ? ch : CH_HASH;
  endfunction

endpackage

/* src/morse_code_codec_unit.sv */
// ----------------------------------------------------------------------------
// morse_code_codec_unit
// Byte-stream Morse encoder/decoder with a direction register.
// ----------------------------------------------------------------------------
// Bytes enter through a push/full port and results leave through an
// empty/pop port, one result byte per cycle while the consumer pops. The
// front end takes one input byte per cycle while full is low; bytes that
// make no output (symbols inside a token) place no job but still wait while
// full is high. Each byte that makes output places one job in a queue of
// JobDepth entries, and the back end expands it into its result bytes, one
// per cycle while the output is popped, so full rises once the queue is
// full. A result passes through the job queue, the current-job register and
// the output register before it shows on the output ports. Writing direction
// (cfg_we_i) clears the open token and the line state.
// ----------------------------------------------------------------------------
module morse_code_codec_unit #(
  parameter int unsigned JobDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i
);
  import mcc_pkg::*;

  job_t fe_job, q_job;
  logic fe_push, q_pop, q_avail, accept;

  assign accept = push && !full;

  mcc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .job_push_o  (fe_push),
    .job_o       (fe_job)
  );

  mcc_job_fifo #(
    .Depth (JobDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fe_push),
    .data_i     (fe_job),
    .pop_i      (q_pop),
    .data_o     (q_job),
    .full_o     (full),
    .nonempty_o (q_avail)
  );

  mcc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (q_job),
    .job_avail_i   (q_avail),
    .job_pop_o     (q_pop),
    .pop           (pop),
    .empty         (empty),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

/* src/mcc_front.sv */
// ----------------------------------------------------------------------------
// mcc_front
// Takes input bytes, keeps the token and line state, and issues output jobs.
// ----------------------------------------------------------------------------
module mcc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    in_byte_i,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  output logic          job_push_o,
  output mcc_pkg::job_t job_o
);
  import mcc_pkg::*;

  logic       dir_q, dir_d;
  logic [5:0] bits_q, bits_d;
  logic [2:0] cnt_q, cnt_d;
  logic       inv_q, inv_d;
  logic       slash_q, slash_d;
  logic       lhc_q, lhc_d;

  logic [7:0] lc_byte;
  pattern_t   pat;

  always_comb begin
    lc_byte = in_byte_i;
    if (in_byte_i inside {[8'h41:8'h5A]}) begin
      lc_byte = in_byte_i | 8'h20;
    end
  end

  assign pat = encode_pattern(lc_byte);

  always_comb begin
    dir_d      = dir_q;
    bits_d     = bits_q;
    cnt_d      = cnt_q;
    inv_d      = inv_q;
    slash_d    = slash_q;
    lhc_d      = lhc_q;
    job_o      = '0;
    job_push_o = 1'b0;
    if (accept_i && !dir_q) begin
      case (in_byte_i)
        CH_DOT, CH_DASH: begin
          if (!inv_q) begin
            if (slash_q || cnt_q == 3'(MaxSymbols)) begin
              inv_d = 1'b1;
            end else begin
              bits_d = {bits_q[4:0], in_byte_i == CH_DASH};
              cnt_d  = cnt_q + 3'd1;
            end
          end
        end
        CH_SLASH: begin
          if (cnt_q != 3'd0 || slash_q || inv_q) begin
            inv_d = 1'b1;
          end else begin
            slash_d = 1'b1;
          end
        end
        CH_BAR, CH_NL: begin
          job_o.has_char = inv_q || slash_q || cnt_q != 3'd0;
          job_o.chr      = inv_q ? CH_HASH : (slash_q ? CH_SPACE : decode_char(cnt_q, bits_q));
          job_o.trail_nl = in_byte_i == CH_NL;
          job_push_o     = job_o.has_char || job_o.trail_nl;
          bits_d         = '0;
          cnt_d          = '0;
          inv_d          = 1'b0;
          slash_d        = 1'b0;
        end
        default: begin
          inv_d = 1'b1;
        end
      endcase
    end else if (accept_i) begin
      job_push_o = 1'b1;
      if (in_byte_i == CH_NL) begin
        job_o.trail_nl = 1'b1;
        lhc_d          = 1'b0;
      end else begin
        job_o.lead_bar = lhc_q;
        lhc_d          = 1'b1;
        if (in_byte_i == CH_SPACE) begin
          job_o.has_char = 1'b1;
          job_o.chr      = CH_SLASH;
        end else if (pat.found) begin
          job_o.nsym     = pat.len;
          job_o.sym_bits = pat.bits << (3'(MaxSymbols) - pat.len);
        end else begin
          job_o.nsym  = 3'd4;
          job_o.sym_e = 1'b1;
        end
      end
    end
    if (cfg_we_i) begin
      dir_d   = cfg_wdata_i;
      bits_d  = '0;
      cnt_d   = '0;
      inv_d   = 1'b0;
      slash_d = 1'b0;
      lhc_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= 1'b0;
      bits_q  <= '0;
      cnt_q   <= '0;
      inv_q   <= 1'b0;
      slash_q <= 1'b0;
      lhc_q   <= 1'b0;
    end else begin
      dir_q   <= dir_d;
      bits_q  <= bits_d;
      cnt_q   <= cnt_d;
      inv_q   <= inv_d;
      slash_q <= slash_d;
      lhc_q   <= lhc_d;
    end
  end

endmodule

/* src/mcc_job_fifo.sv */
// ----------------------------------------------------------------------------
// mcc_job_fifo
// Small queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module mcc_job_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mcc_pkg::job_t data_i,
  input  logic          pop_i,
  output mcc_pkg::job_t data_o,
  output logic          full_o,
  output logic          nonempty_o
);
  import mcc_pkg::*;

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned Cw = $clog2(Depth + 1);

  job_t          mem_q [Depth];
  logic [Aw-1:0] wptr_q, rptr_q;
  logic [Cw-1:0] cnt_q;

  logic do_push, do_pop;

  assign full_o     = cnt_q == Cw'(Depth);
  assign nonempty_o = cnt_q != '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;
  assign data_o     = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == Aw'(Depth - 1)) ? '0 : wptr_q + Aw'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == Aw'(Depth - 1)) ? '0 : rptr_q + Aw'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + Cw'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - Cw'(1);
      end
    end
  end

endmodule

/* src/mcc_back.sv */
// ----------------------------------------------------------------------------
// mcc_back
// Expands jobs into output bytes, one per cycle while the output register is free or popped.
// ----------------------------------------------------------------------------
module mcc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mcc_pkg::job_t job_i,
  input  logic          job_avail_i,
  output logic          job_pop_o,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte_o,
  output logic          last_of_run_o
);
  import mcc_pkg::*;

  job_t       cur_q, cur_d;
  logic       cur_valid_q, cur_valid_d;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  logic       adv, emit, remaining, take;
  logic [7:0] nbyte;
  job_t       step;

  assign adv  = !out_valid_q || pop;
  assign emit = adv && cur_valid_q;

  always_comb begin
    step = cur_q;
    if (cur_q.lead_bar) begin
      nbyte         = CH_BAR;
      step.lead_bar = 1'b0;
    end else if (cur_q.nsym != 3'd0) begin
      nbyte         = cur_q.sym_e ? CH_E : (cur_q.sym_bits[5] ? CH_DASH : CH_DOT);
      step.nsym     = cur_q.nsym - 3'd1;
      step.sym_bits = {cur_q.sym_bits[4:0], 1'b0};
    end else if (cur_q.has_char) begin
      nbyte         = cur_q.chr;
      step.has_char = 1'b0;
    end else begin
      nbyte         = CH_NL;
      step.trail_nl = 1'b0;
    end
    remaining = step.lead_bar || step.nsym != 3'd0 || step.has_char || step.trail_nl;
  end

  assign take      = !cur_valid_q || (emit && !remaining);
  assign job_pop_o = take && job_avail_i;

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    if (take) begin
      cur_d       = job_i;
      cur_valid_d = job_avail_i;
    end else if (emit) begin
      cur_d = step;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (emit) begin
      out_byte_q <= nbyte;
      out_last_q <= !remaining;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      if (adv) begin
        out_valid_q <= emit;
      end
    end
  end

  assign empty         = !out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

endmodule
